>>> rtl/core/bbl_pkg.sv
package bbl_pkg;

    localparam int MAX_RADIUS = 63;
    localparam int RAD_W      = 6;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int RING_DEPTH = 2 * MAX_RADIUS + 2;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    // window count 1 .. 2*MAX_RADIUS+1
    localparam int CNT_W      = $clog2(2 * MAX_RADIUS + 2);
    // running sum of up to 2*MAX_RADIUS+1 samples
    localparam int SUM_W      = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
    localparam int QUOT_W     = CH_W;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } t_rgb8;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } t_rgb_sum;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        t_rgb_sum         sums;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_rgb8 quot;
    } t_div_rsp;

endpackage

>>> rtl/core/bbl_if.sv
interface bbl_pix_in_if;
    logic                      valid;
    logic                      ready;
    logic [bbl_pkg::CH_W-1:0]  red_in;
    logic [bbl_pkg::CH_W-1:0]  green_in;
    logic [bbl_pkg::CH_W-1:0]  blue_in;
    logic                      line_end;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output line_end, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input line_end, output ready);
endinterface

interface bbl_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic [bbl_pkg::CH_W-1:0]  red_out;
    logic [bbl_pkg::CH_W-1:0]  green_out;
    logic [bbl_pkg::CH_W-1:0]  blue_out;
    logic                      line_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output line_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input line_last, output ready);
endinterface

>>> rtl/core/box_blur_line_rgb.sv
// channel   dir  payload                                   beat taken when
// i_pix     in   red_in, green_in, blue_in, line_end        valid && ready
// o_pix     out  red_out, green_out, blue_out, line_last    valid && ready
// i_cfg_*   in   radius (6 bit)                             i_cfg_wr_en high
//
// a pixel may yield no result; one that yields a result waits for a free output
// (the shared divider forms the quotient bit by bit, on all three channels together)
// flush on line end: per extra result, pixels past the window are dropped first
// reset is synchronous; radius returns to 1, sums and counts clear
// the ring holds no reset: only pixels written earlier in the line are used
// a stalled output holds one result; the next input beat is still taken
module box_blur_line_rgb (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [bbl_pkg::RAD_W-1:0] i_cfg_wr_data,
    bbl_pix_in_if.sink                i_pix,
    bbl_pix_out_if.source             o_pix
);
    import bbl_pkg::*;

    localparam int EW = CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DSTART,
        S_DIV,
        S_OUT,
        S_MAIN_END,
        S_FCHK,
        S_FDROP
    } t_state;

    // sequencer state
    t_state             r_state, n_state;
    logic [RAD_W-1:0]   r_radius, n_radius;   // config register
    logic [RAD_W-1:0]   r_rad, n_rad;         // radius latched for the line
    logic [CNT_W-1:0]   r_ps, n_ps;           // pixels now in the sums
    logic [RING_AW-1:0] r_pos, n_pos;         // ring write pointer
    t_rgb_sum           r_sum, n_sum;
    t_rgb8              r_px, n_px;
    logic               r_end, n_end;
    logic               r_drop, n_drop;
    logic               r_flush, n_flush;
    logic [RAD_W-1:0]   r_k, n_k;             // flush outputs still to go, minus one
    logic               r_last, n_last;
    // output register
    logic               r_ovalid, n_ovalid;
    t_rgb8              r_out, n_out;
    logic               r_olast, n_olast;

    logic               in_beat;
    logic [RAD_W-1:0]   rad_sel;
    logic [CNT_W-1:0]   win_sel;
    logic [CNT_W-1:0]   win;
    logic [CNT_W-1:0]   ps_inc;
    logic               emit_main;
    logic               need_drop;
    logic [CNT_W-1:0]   ps_m1;
    logic [CNT_W-1:0]   rad_m1;
    logic [RAD_W-1:0]   kmax;
    logic               out_load;

    logic               ram_we;
    logic               ram_re;
    logic [RING_AW-1:0] ram_raddr;
    logic [PIX_W-1:0]   ram_rdata;
    t_rgb8              rd_px;
    t_rgb8              drop_px;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign in_beat     = i_pix.valid && (r_state == S_IDLE);
    assign i_pix.ready = (r_state == S_IDLE);

    // first pixel of a line takes the configured radius
    assign rad_sel = (r_ps == '0) ? r_radius : r_rad;
    assign win_sel = {rad_sel, 1'b1};
    assign win     = {r_rad, 1'b1};

    assign ps_inc    = (r_ps < win) ? r_ps + 1'b1 : r_ps;
    assign emit_main = (ps_inc >= ({1'b0, r_rad} + 1'b1));

    // during flush, shrink the window while it reaches past pixel j + radius
    assign need_drop = (EW'(r_ps) > (EW'(r_k) + EW'(1) + EW'(r_rad)));

    assign ps_m1  = r_ps - 1'b1;
    assign rad_m1 = {1'b0, r_rad} - 1'b1;
    assign kmax   = (ps_m1 < rad_m1) ? ps_m1[RAD_W-1:0] : rad_m1[RAD_W-1:0];

    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_pix.ready);

    // ring: oldest pixel of the window on a new beat, window head on flush
    assign ram_we    = (r_state == S_ADD);
    assign ram_re    = in_beat || ((r_state == S_FCHK) && need_drop);
    assign ram_raddr = (r_state == S_IDLE) ? r_pos - win_sel : r_pos - r_ps;
    assign rd_px     = t_rgb8'(ram_rdata);
    assign drop_px   = r_drop ? rd_px : '0;

    bbl_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_pos),
        .i_wr_data (r_px),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign div_req.start = (r_state == S_DSTART);
    assign div_req.count = r_ps;
    assign div_req.sums  = r_sum;

    bbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state  = r_state;
        n_radius = i_cfg_wr_en ? i_cfg_wr_data : r_radius;
        n_rad    = r_rad;
        n_ps     = r_ps;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_px     = r_px;
        n_end    = r_end;
        n_drop   = r_drop;
        n_flush  = r_flush;
        n_k      = r_k;
        n_last   = r_last;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        n_olast  = r_olast;

        // output register: load a finished result or free up on a taken beat
        if (out_load) begin
            n_ovalid = 1'b1;
            n_out    = div_rsp.quot;
            n_olast  = r_last;
        end else if (o_pix.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_rad   = rad_sel;
                    n_px.r  = i_pix.red_in;
                    n_px.g  = i_pix.green_in;
                    n_px.b  = i_pix.blue_in;
                    n_end   = i_pix.line_end;
                    n_drop  = (r_ps >= win_sel);
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                // slide the window: drop the oldest once the window is full, add the new pixel
                n_sum.r = r_sum.r - SUM_W'(drop_px.r) + SUM_W'(r_px.r);
                n_sum.g = r_sum.g - SUM_W'(drop_px.g) + SUM_W'(r_px.g);
                n_sum.b = r_sum.b - SUM_W'(drop_px.b) + SUM_W'(r_px.b);
                n_pos   = r_pos + 1'b1;
                n_ps    = ps_inc;
                n_last  = r_end && (r_rad == '0);
                n_flush = 1'b0;
                n_state = emit_main ? S_DSTART : S_MAIN_END;
            end
            S_DSTART: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    if (!r_flush) begin
                        n_state = S_MAIN_END;
                    end else if (r_k == '0) begin
                        n_sum   = '0;
                        n_ps    = '0;
                        n_flush = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = S_FCHK;
                    end
                end
            end
            S_MAIN_END: begin
                if (r_end && (r_rad != '0)) begin
                    n_flush = 1'b1;
                    n_k     = kmax;
                    n_state = S_FCHK;
                end else begin
                    if (r_end) begin
                        n_sum = '0;
                        n_ps  = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FCHK: begin
                if (need_drop) begin
                    n_state = S_FDROP;
                end else begin
                    n_last  = (r_k == '0);
                    n_state = S_DSTART;
                end
            end
            S_FDROP: begin
                n_sum.r = r_sum.r - SUM_W'(rd_px.r);
                n_sum.g = r_sum.g - SUM_W'(rd_px.g);
                n_sum.b = r_sum.b - SUM_W'(rd_px.b);
                n_ps    = r_ps - 1'b1;
                n_state = S_FCHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radius <= RAD_W'(1);
            r_rad    <= '0;
            r_ps     <= '0;
            r_pos    <= '0;
            r_sum    <= '0;
            r_flush  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_radius <= n_radius;
            r_rad    <= n_rad;
            r_ps     <= n_ps;
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_flush  <= n_flush;
            r_ovalid <= n_ovalid;
        end
        r_px    <= n_px;
        r_end   <= n_end;
        r_drop  <= n_drop;
        r_k     <= n_k;
        r_last  <= n_last;
        r_out   <= n_out;
        r_olast <= n_olast;
    end

    assign o_pix.valid     = r_ovalid;
    assign o_pix.red_out   = r_out.r;
    assign o_pix.green_out = r_out.g;
    assign o_pix.blue_out  = r_out.b;
    assign o_pix.line_last = r_olast;

    a_ps_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ps <= {r_rad, 1'b1})
        else $error("pixel count beyond window");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && !o_pix.ready) |=> (r_state == S_OUT))
        else $error("result dropped while output stalled");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside wait state");

    a_flush_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush && r_state == S_FCHK) |-> (r_k < r_rad))
        else $error("flush count beyond radius");
endmodule

>>> rtl/core/bbl_ram.sv
module bbl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/core/bbl_div.sv
module bbl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbl_pkg::t_div_req i_req,
    output bbl_pkg::t_div_rsp o_rsp
);
    import bbl_pkg::*;

    localparam int DIV_W = CNT_W + QUOT_W - 1;
    localparam int CW    = $clog2(QUOT_W);

    // restoring division, one quotient bit per cycle on all three channels
    logic [DIV_W-1:0] r_div;
    t_rgb_sum         r_rem;
    t_rgb8            r_q;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SUM_W:0]   step_r;
    logic [SUM_W:0]   step_g;
    logic [SUM_W:0]   step_b;

    function automatic logic [SUM_W:0] div_step(input logic [SUM_W-1:0] rem,
                                                input logic [DIV_W-1:0] d);
        logic             ge;
        logic [SUM_W-1:0] dd;
        dd = SUM_W'(d);
        ge = (rem >= dd);
        return {ge, ge ? rem - dd : rem};
    endfunction

    assign step_r = div_step(r_rem.r, r_div);
    assign step_g = div_step(r_rem.g, r_div);
    assign step_b = div_step(r_rem.b, r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QUOT_W - 1);
                r_div  <= DIV_W'(i_req.count) << (QUOT_W - 1);
                r_rem  <= i_req.sums;
            end else if (r_busy) begin
                r_rem.r <= step_r[SUM_W-1:0];
                r_rem.g <= step_g[SUM_W-1:0];
                r_rem.b <= step_b[SUM_W-1:0];
                r_q.r   <= {r_q.r[QUOT_W-2:0], step_r[SUM_W]};
                r_q.g   <= {r_q.g[QUOT_W-2:0], step_g[SUM_W]};
                r_q.b   <= {r_q.b[QUOT_W-2:0], step_b[SUM_W]};
                r_div   <= r_div >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
endmodule
